>>> rtl/assert_macros.svh
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of a given clock, off while reset is low.
`define ASSERT_AT(label, clk_sig, rst_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
		else $error(msg);

// Same, on the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

>>> rtl/gfmd_pkg.sv
package gfmd_pkg;

	// Frame and mixer constants
	localparam logic [7:0] HEADER_BYTE = 8'h80;
	localparam logic [7:0] CENTRE      = 8'h40;
	localparam int         WINDOW_LEN  = 7;
	localparam int         PAYLOAD_LEN = 6;

	// Mode counter
	localparam int                    MODE_W     = 3;
	localparam int                    MODE_COUNT = 5;
	localparam logic [MODE_W-1:0]     MODE_LAST  = MODE_W'(MODE_COUNT - 1);

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_DATA_W-1:0] STEP_DOWN_RESET = 8'd4;
	localparam logic [CFG_DATA_W-1:0] STEP_UP_RESET   = 8'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_DOWN = 1'b0,
		REG_STEP_UP   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                  we;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// One classified byte, as handed from front to back
	typedef struct packed {
		logic       frame;
		logic [7:0] btn_first;
		logic [7:0] btn_second;
		logic [7:0] left_rl;
		logic [7:0] left_ud;
		logic [7:0] right_rl;
		logic [7:0] check_rx;
		logic [6:0] check_sum;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		logic              frame_seen;
		logic [MODE_W-1:0] mode_now;
		logic [7:0]        buttons_first;
		logic [7:0]        buttons_second;
		logic [7:0]        check_received;
		logic [6:0]        check_computed;
		logic [7:0]        right_front_level;
		logic [7:0]        right_rear_level;
		logic [7:0]        left_front_level;
		logic [7:0]        left_rear_level;
		logic [3:0]        reverse_bits;
	} result_t;

endpackage

>>> rtl/gfmd_if.sv
// Byte channel from the serial receiver
interface gfmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel toward the motor drivers
interface gfmd_result_if;
	logic              valid;
	logic              ready;
	gfmd_pkg::result_t result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

>>> rtl/gfmd_front.sv
module gfmd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	gfmd_byte_if.sink             rx_link,
	input  gfmd_pkg::queue_stat_t stat,
	output gfmd_pkg::push_t       push
);

	logic [7:0]  win_q [gfmd_pkg::WINDOW_LEN];
	logic [7:0]  btn_first_q;
	logic [7:0]  btn_second_q;
	logic [7:0]  left_rl_q;
	logic [7:0]  left_ud_q;
	logic [7:0]  right_rl_q;
	logic [7:0]  check_rx_q;
	logic [6:0]  check_sum_q;
	logic        accept;
	logic        frame;
	logic [10:0] sum;

	assign rx_link.ready = !stat.full;
	assign accept        = rx_link.valid && !stat.full;
	assign frame         = (win_q[gfmd_pkg::WINDOW_LEN-1] == gfmd_pkg::HEADER_BYTE);

	// Add the six payload bytes sitting behind the header
	always_comb begin
		sum = '0;
		for (int i = 0; i < gfmd_pkg::PAYLOAD_LEN; i++) begin
			sum = sum + 11'(win_q[i]);
		end
	end

	// Build the word for the back end: fresh frame fields or the held ones
	always_comb begin
		push.valid            = accept;
		push.entry.frame      = frame;
		push.entry.btn_first  = frame ? win_q[5] : btn_first_q;
		push.entry.btn_second = frame ? win_q[4] : btn_second_q;
		push.entry.left_rl    = frame ? win_q[3] : left_rl_q;
		push.entry.left_ud    = frame ? win_q[2] : left_ud_q;
		push.entry.right_rl   = frame ? win_q[1] : right_rl_q;
		push.entry.check_rx   = frame ? rx_link.rx_byte : check_rx_q;
		push.entry.check_sum  = frame ? sum[6:0] : check_sum_q;
	end

	// Shift the window and latch a completed frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gfmd_pkg::WINDOW_LEN; i++) begin
				win_q[i] <= '0;
			end
			btn_first_q  <= '0;
			btn_second_q <= '0;
			left_rl_q    <= '0;
			left_ud_q    <= '0;
			right_rl_q   <= '0;
			check_rx_q   <= '0;
			check_sum_q  <= '0;
		end else if (accept) begin
			for (int i = gfmd_pkg::WINDOW_LEN - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= rx_link.rx_byte;
			if (frame) begin
				btn_first_q  <= push.entry.btn_first;
				btn_second_q <= push.entry.btn_second;
				left_rl_q    <= push.entry.left_rl;
				left_ud_q    <= push.entry.left_ud;
				right_rl_q   <= push.entry.right_rl;
				check_rx_q   <= push.entry.check_rx;
				check_sum_q  <= push.entry.check_sum;
			end
		end
	end

endmodule

>>> rtl/gfmd_queue.sv
module gfmd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gfmd_pkg::push_t       push,
	input  logic                  pop,
	output gfmd_pkg::entry_t      head,
	output gfmd_pkg::queue_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	gfmd_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;

	// Store incoming words
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/gfmd_back.sv
module gfmd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gfmd_pkg::cfg_wr_t     cfg,
	input  gfmd_pkg::entry_t      head,
	input  gfmd_pkg::queue_stat_t stat,
	output logic                  pop,
	gfmd_result_if.source         result_link
);

	typedef struct packed {
		logic [7:0] mag;
		logic       dir;
	} wheel_t;

	logic [7:0]                    down_mask_q;
	logic [7:0]                    up_mask_q;
	logic [gfmd_pkg::MODE_W-1:0]   mode_q;
	logic [3:0]                    dir_q;
	logic                          out_valid_q;
	gfmd_pkg::result_t             result_q;
	logic [gfmd_pkg::MODE_W-1:0]   mode_next;
	logic signed [10:0]            f;
	logic signed [10:0]            r;
	logic signed [10:0]            t;
	logic signed [10:0]            term_rf;
	logic signed [10:0]            term_rr;
	logic signed [10:0]            term_lf;
	logic signed [10:0]            term_lr;
	wheel_t                        w_rf;
	wheel_t                        w_rr;
	wheel_t                        w_lf;
	wheel_t                        w_lr;
	gfmd_pkg::result_t             result_next;

	// A stick at zero reads as centered
	function automatic logic signed [10:0] centred(input logic [7:0] v);
		logic [7:0] c;
		c = (v == '0) ? gfmd_pkg::CENTRE : v;
		return signed'({3'b000, c});
	endfunction

	// Clamp a term to one byte of magnitude; a zero term keeps the old direction
	function automatic wheel_t drive(input logic signed [10:0] term, input logic neg_sets,
		input logic old_dir);
		wheel_t           w;
		logic             neg;
		logic [10:0]      mag;
		neg = term[10];
		mag = neg ? 11'(-term) : 11'(term);
		if (term == '0) begin
			w.mag = '0;
			w.dir = old_dir;
		end else begin
			w.mag = (mag > 11'd255) ? 8'd255 : mag[7:0];
			w.dir = (neg == neg_sets);
		end
		return w;
	endfunction

	assign pop = !stat.empty && (!out_valid_q || result_link.ready);

	// Step the mode on a frame: down first, then up
	always_comb begin
		mode_next = mode_q;
		if (head.frame && |(head.btn_first & down_mask_q)) begin
			mode_next = (mode_next == '0) ? gfmd_pkg::MODE_LAST : mode_next - 1'b1;
		end
		if (head.frame && |(head.btn_first & up_mask_q)) begin
			mode_next = (mode_next >= gfmd_pkg::MODE_LAST) ? '0 : mode_next + 1'b1;
		end
	end

	// Mix the sticks into the four wheel terms
	always_comb begin
		f       = centred(head.left_ud);
		r       = centred(head.left_rl);
		t       = centred(head.right_rl);
		term_rf = f + r + t - 11'sd192;
		term_rr = f - r + t - 11'sd64;
		term_lf = f - r - t + 11'sd64;
		term_lr = f + r - t - 11'sd64;
		w_rf    = drive(term_rf, 1'b1, dir_q[0]);
		w_rr    = drive(term_rr, 1'b1, dir_q[1]);
		w_lf    = drive(term_lf, 1'b0, dir_q[2]);
		w_lr    = drive(term_lr, 1'b0, dir_q[3]);
	end

	// Assemble the outgoing word
	always_comb begin
		result_next.frame_seen        = head.frame;
		result_next.mode_now          = mode_next;
		result_next.buttons_first     = head.btn_first;
		result_next.buttons_second    = head.btn_second;
		result_next.check_received    = head.check_rx;
		result_next.check_computed    = head.check_sum;
		result_next.right_front_level = w_rf.mag;
		result_next.right_rear_level  = w_rr.mag;
		result_next.left_front_level  = w_lf.mag;
		result_next.left_rear_level   = w_lr.mag;
		result_next.reverse_bits      = {w_lr.dir, w_lf.dir, w_rr.dir, w_rf.dir};
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_mask_q <= gfmd_pkg::STEP_DOWN_RESET;
			up_mask_q   <= gfmd_pkg::STEP_UP_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				gfmd_pkg::REG_STEP_DOWN: down_mask_q <= cfg.data;
				gfmd_pkg::REG_STEP_UP:   up_mask_q   <= cfg.data;
			endcase
		end
	end

	// Advance mode and direction state, hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			dir_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			mode_q      <= mode_next;
			dir_q       <= result_next.reverse_bits;
			out_valid_q <= 1'b1;
		end else if (result_link.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= result_next;
		end
	end

	assign result_link.valid  = out_valid_q;
	assign result_link.result = result_q;

endmodule

>>> rtl/gamepad_frame_mecanum_drive_top.sv
// Channel      Role    Word per handshake
// rx_link      sink    one received serial byte (rx_byte)
// result_link  source  frame flag, mode, latched frame fields, four PWM levels, directions
// cfg          write   step_down_mask (index 0), step_up_mask (index 1)
//
// One byte is taken per cycle unless the queue is full; its result is registered at the output.
// The front registers the byte window, a small queue holds classified words, and
// the back computes the mix into an output register.
// A stalled result port fills the queue; rx_link.ready drops only when it is full.
// Reset clears the window, latched frame fields, mode and directions, and loads the mask defaults.
`include "assert_macros.svh"

module gamepad_frame_mecanum_drive_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gfmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gfmd_pkg::CFG_DATA_W-1:0]    cfg_data,
	gfmd_byte_if.sink                          rx_link,
	gfmd_result_if.source                      result_link
);

	gfmd_pkg::push_t       push;
	gfmd_pkg::entry_t      head;
	gfmd_pkg::queue_stat_t stat;
	gfmd_pkg::cfg_wr_t     cfg;
	logic                  pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = gfmd_pkg::cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_data;

	gfmd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_link (rx_link),
		.stat    (stat),
		.push    (push)
	);

	gfmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (stat)
	);

	gfmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.result_link (result_link)
	);

	`ASSERT_STD(a_no_push_full, push.valid |-> !stat.full, "push into full queue")
	`ASSERT_STD(a_no_pop_empty, pop |-> !stat.empty, "pop from empty queue")
	`ASSERT_STD(a_accept_queued, (rx_link.valid && rx_link.ready) |=> !stat.empty, "byte lost")
	`ASSERT_STD(a_mode_range, result_link.valid |-> result_link.result.mode_now <= gfmd_pkg::MODE_LAST, "mode out of range")

endmodule

>>> sim/tb_top.sv
module tb_top;
	import gfmd_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int BYTES_PER_PHASE = 320;
	localparam int PHASES          = 6;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PRINT_CAP       = 100;
	localparam int PWM_MAX         = 255;
	localparam int MID             = int'(CENTRE);

	// One directed step: the byte, and a hand-typed word where one is given
	typedef struct packed {
		logic       typed;
		logic [7:0] rx;
		result_t    word;
	} step_row_t;

	localparam result_t IDLE_WORD = '0;

	// Full-scale sticks, both masks hit: mode wraps down then back up
	localparam result_t HIGH_WORD = '{
		frame_seen: 1'b1, mode_now: 3'd0, buttons_first: 8'hFF, buttons_second: 8'h00,
		check_received: 8'h7F, check_computed: 7'h7B,
		right_front_level: 8'd255, right_rear_level: 8'd191,
		left_front_level: 8'd191, left_rear_level: 8'd191, reverse_bits: 4'b1000};

	// Lowest non-centre sticks, step up only
	localparam result_t LOW_WORD = '{
		frame_seen: 1'b1, mode_now: 3'd1, buttons_first: 8'h08, buttons_second: 8'hFF,
		check_received: 8'h00, check_computed: 7'h0B,
		right_front_level: 8'd189, right_rear_level: 8'd63,
		left_front_level: 8'd63, left_rear_level: 8'd63, reverse_bits: 4'b0111};

	// Zero sticks read as centre: every term zero, directions held
	localparam result_t CENTRE_WORD = '{
		frame_seen: 1'b1, mode_now: 3'd0, buttons_first: 8'h04, buttons_second: 8'h00,
		check_received: 8'hFF, check_computed: 7'h04,
		right_front_level: 8'd0, right_rear_level: 8'd0,
		left_front_level: 8'd0, left_rear_level: 8'd0, reverse_bits: 4'b0111};

	localparam step_row_t DIRECTED [24] = '{
		'{1'b1, 8'h80, IDLE_WORD}, '{1'b1, 8'hFF, IDLE_WORD},
		'{1'b1, 8'h00, IDLE_WORD}, '{1'b1, 8'hFF, IDLE_WORD},
		'{1'b1, 8'hFF, IDLE_WORD}, '{1'b1, 8'hFF, IDLE_WORD},
		'{1'b1, 8'hFF, IDLE_WORD}, '{1'b1, 8'h7F, HIGH_WORD},
		'{1'b0, 8'h80, IDLE_WORD}, '{1'b0, 8'h08, IDLE_WORD},
		'{1'b0, 8'hFF, IDLE_WORD}, '{1'b0, 8'h01, IDLE_WORD},
		'{1'b0, 8'h01, IDLE_WORD}, '{1'b0, 8'h01, IDLE_WORD},
		'{1'b0, 8'h01, IDLE_WORD}, '{1'b1, 8'h00, LOW_WORD},
		'{1'b0, 8'h80, IDLE_WORD}, '{1'b0, 8'h04, IDLE_WORD},
		'{1'b0, 8'h00, IDLE_WORD}, '{1'b0, 8'h00, IDLE_WORD},
		'{1'b0, 8'h00, IDLE_WORD}, '{1'b0, 8'h00, IDLE_WORD},
		'{1'b0, 8'h00, IDLE_WORD}, '{1'b1, 8'hFF, CENTRE_WORD}};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gfmd_byte_if   rx_link ();
	gfmd_result_if result_link ();

	gamepad_frame_mecanum_drive_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rx_link    (rx_link),
		.result_link(result_link)
	);

	// Mixer state as the block should hold it
	logic [7:0]        win [WINDOW_LEN] = '{default: '0};
	logic [7:0]        sticks [4]       = '{default: '0};
	logic [7:0]        btn [2]          = '{default: '0};
	logic [7:0]        chk_byte         = '0;
	logic [6:0]        pay_sum          = '0;
	logic [MODE_W-1:0] mode             = '0;
	logic [3:0]        dir              = '0;
	logic [7:0]        down_mask        = STEP_DOWN_RESET;
	logic [7:0]        up_mask          = STEP_UP_RESET;

	result_t pending_words [$];
	int      mismatches = 0;
	int      cycles     = 0;
	logic    typed_flag = 1'b0;
	result_t typed_word = '0;
	int      tx_quiet   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int centred(input logic [7:0] v);
		return (v == 8'd0) ? MID : int'(v);
	endfunction

	// Clamp one wheel term, update its direction bit, return the PWM level
	function automatic logic [7:0] wheel_drive(input int term, input logic neg_sets,
			inout logic dir_bit);
		if (term == 0)
			return 8'd0;
		if (term < -PWM_MAX)
			term = -PWM_MAX;
		if (term > PWM_MAX)
			term = PWM_MAX;
		dir_bit = ((term < 0) == neg_sets);
		return 8'((term < 0) ? -term : term);
	endfunction

	// Advance the window by one byte and work out the word it should produce
	function automatic result_t mix_byte(input logic [7:0] b);
		result_t w;
		logic    frame;
		int      k;
		int      sum;
		int      f;
		int      r;
		int      t;
		frame = (win[WINDOW_LEN-1] == HEADER_BYTE);
		if (frame) begin
			btn[0] = win[5];
			btn[1] = win[4];
			for (k = 0; k < 4; k++)
				sticks[k] = win[3-k];
			chk_byte = b;
			sum = 0;
			for (k = 0; k < PAYLOAD_LEN; k++)
				sum += win[k];
			pay_sum = sum[6:0];
			// step down first, then up
			if ((btn[0] & down_mask) != 8'd0)
				mode = (mode == '0) ? MODE_LAST : mode - 1'b1;
			if ((btn[0] & up_mask) != 8'd0)
				mode = (mode >= MODE_LAST) ? '0 : mode + 1'b1;
		end
		for (k = WINDOW_LEN - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = b;

		f = centred(sticks[1]);
		r = centred(sticks[0]);
		t = centred(sticks[2]);
		w.frame_seen        = frame;
		w.mode_now          = mode;
		w.buttons_first     = btn[0];
		w.buttons_second    = btn[1];
		w.check_received    = chk_byte;
		w.check_computed    = pay_sum;
		w.right_front_level = wheel_drive(f + r - 128 + t - MID, 1'b1, dir[0]);
		w.right_rear_level  = wheel_drive(f - r + t - MID, 1'b1, dir[1]);
		w.left_front_level  = wheel_drive(f - r - t + MID, 1'b0, dir[2]);
		w.left_rear_level   = wheel_drive(f + r - 128 - t + MID, 1'b0, dir[3]);
		w.reverse_bits      = dir;
		return w;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Predict on every accepted byte, check every accepted word
	always @(posedge clk) begin : scoreboard
		result_t want;
		result_t got;
		if (arst_n) begin
			if (rx_link.valid && rx_link.ready) begin
				want = mix_byte(rx_link.rx_byte);
				if (typed_flag)
					want = typed_word;
				pending_words.push_back(want);
			end
			if (result_link.valid && result_link.ready) begin
				got = result_link.result;
				if (pending_words.size() == 0) begin
					flag_mismatch("result word with nothing pending");
				end else begin
					want = pending_words.pop_front();
					check_field("frame_seen", got.frame_seen, want.frame_seen);
					check_field("mode_now", got.mode_now, want.mode_now);
					check_field("buttons_first", got.buttons_first, want.buttons_first);
					check_field("buttons_second", got.buttons_second, want.buttons_second);
					check_field("check_received", got.check_received, want.check_received);
					check_field("check_computed", got.check_computed, want.check_computed);
					check_field("right_front_level", got.right_front_level,
						want.right_front_level);
					check_field("right_rear_level", got.right_rear_level,
						want.right_rear_level);
					check_field("left_front_level", got.left_front_level,
						want.left_front_level);
					check_field("left_rear_level", got.left_rear_level, want.left_rear_level);
					check_field("reverse_bits", got.reverse_bits, want.reverse_bits);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stalls with occasional steady stretches
	initial begin : result_sink
		int   hold;
		int   quiet;
		logic rdy;
		hold  = 0;
		quiet = 0;
		rdy   = 1'b1;
		result_link.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet > 0)
				quiet--;
			else if ($urandom_range(0, 199) == 0)
				quiet = 80;
			if (hold == 0) begin
				if (rdy) begin
					hold = (quiet > 0) ? 0 : pick_gap();
					if (hold > 0)
						rdy = 1'b0;
					else
						hold = $urandom_range(1, 8);
				end else begin
					rdy  = 1'b1;
					hold = $urandom_range(1, 12);
				end
			end
			hold--;
			result_link.ready <= rdy;
		end
	end

	// Offer one byte after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic typed, input result_t word);
		int gap;
		gap = pick_gap();
		if (tx_quiet > 0) begin
			gap = 0;
			tx_quiet--;
		end
		if (gap > 0) begin
			rx_link.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_flag = typed;
		typed_word = word;
		rx_link.valid   <= 1'b1;
		rx_link.rx_byte <= b;
		do
			@(posedge clk);
		while (!(rx_link.valid && rx_link.ready));
		@(negedge clk);
	endtask

	// Drop valid, drain every pending word, then let the pipe settle
	task automatic wait_idle();
		rx_link.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_masks(input logic [7:0] down, input logic [7:0] up);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STEP_DOWN;
		cfg_data  <= down;
		@(posedge clk);
		down_mask = down;
		@(negedge clk);
		cfg_index <= REG_STEP_UP;
		cfg_data  <= up;
		@(posedge clk);
		up_mask = up;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_stick();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return 8'h00;
			5, 6:          return CENTRE;
			7, 8:          return 8'h01;
			9, 10:         return 8'hFF;
			default:       return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_buttons();
		case ($urandom_range(0, 9))
			0, 1:    return 8'h00;
			2, 3:    return 8'(1 << $urandom_range(0, 7));
			4, 5:    return (down_mask | up_mask) & 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed frames with random content, plus noise, cut frames and header runs
	task automatic run_random(input int n_bytes);
		logic [7:0] frame_bytes [8];
		int         sent;
		int         len;
		int         roll;
		int         k;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(0, 33) == 0)
				tx_quiet = 60;
			frame_bytes[0] = HEADER_BYTE;
			frame_bytes[1] = pick_buttons();
			frame_bytes[2] = 8'($urandom_range(0, 255));
			for (k = 3; k < 7; k++)
				frame_bytes[k] = pick_stick();
			frame_bytes[7] = 8'($urandom_range(0, 255));
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				len = 8;
			end else if (roll < 85) begin
				len = $urandom_range(2, 7);
			end else if (roll < 95) begin
				len = $urandom_range(1, 5);
				for (k = 0; k < len; k++)
					frame_bytes[k] = 8'($urandom_range(0, 255));
			end else begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					frame_bytes[k] = HEADER_BYTE;
			end
			for (k = 0; k < len; k++)
				send_byte(frame_bytes[k], 1'b0, IDLE_WORD);
			sent += len;
		end
	endtask

	initial begin : stimulus
		logic [7:0] down_set [PHASES];
		logic [7:0] up_set [PHASES];
		int         i;
		down_set = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, STEP_DOWN_RESET};
		up_set   = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, STEP_UP_RESET};
		down_set[3] = 8'($urandom_range(0, 255));
		up_set[3]   = 8'($urandom_range(0, 255));

		rx_link.valid   = 1'b0;
		rx_link.rx_byte = 8'h00;
		cfg_we          = 1'b0;
		cfg_index       = REG_STEP_DOWN;
		cfg_data        = '0;
		arst_n          = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under reset masks
		for (i = 0; i < $size(DIRECTED); i++)
			send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].word);

		// Random traffic, one mask setting per phase
		for (i = 0; i < PHASES; i++) begin
			wait_idle();
			set_masks(down_set[i], up_set[i]);
			run_random(BYTES_PER_PHASE);
		end

		wait_idle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gfmd_pkg.sv
rtl/gfmd_if.sv
rtl/gfmd_front.sv
rtl/gfmd_queue.sv
rtl/gfmd_back.sv
rtl/gamepad_frame_mecanum_drive_top.sv
sim/tb_top.sv
